>>> rtl/core/rmgs_pkg.sv
// Package for the ratio merge geometric score block.
// Holds op codes, sequencer states and shared sizes; depends on nothing.
package rmgs_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned OP_W   = 3;

  typedef enum logic [2:0] {
    OP_START  = 3'd0,
    OP_MERGE  = 3'd1,
    OP_APPEND = 3'd2,
    OP_SCALE  = 3'd3,
    OP_SCORE  = 3'd4,
    OP_REDUCE = 3'd5
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCALE_MEAN,
    ST_SCALE_RD,
    ST_SCALE_WAIT,
    ST_SCALE_MUL,
    ST_CPY_RD,
    ST_CPY_WR,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SQRT,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_FIN_RD,
    ST_FIN,
    ST_OUT
  } state_e;

endpackage

>>> rtl/core/rmgs_divider.sv
// Restoring divider, one quotient bit per cycle, 64 by 33 bits.
// Depends on rmgs_pkg.
module rmgs_divider
  import rmgs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [32:0] divisor_i,
  output logic        busy_o,
  output logic [63:0] quot_o
);

  logic [63:0] quot_q, quot_d;
  logic [33:0] rem_q, rem_d;
  logic [32:0] dsr_q, dsr_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [33:0] trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = '0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q[32:0], quot_q[63]};
      if (trial >= {1'b0, dsr_q}) begin
        rem_d  = trial - {1'b0, dsr_q};
        quot_d = {quot_q[62:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

>>> rtl/core/rmgs_isqrt.sv
// Integer square root of a 64-bit word, one result bit per cycle.
// Depends on rmgs_pkg.
module rmgs_isqrt
  import rmgs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic        busy_o,
  output logic [31:0] root_o
);

  logic [63:0] rad_q, rad_d;
  logic [33:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [33:0] trial;
  logic [33:0] sub;

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[31:0], rad_q[63:62]};
    sub    = {root_q, 2'b01};
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[61:0], 2'b00};
      if (trial >= sub) begin
        rem_d  = trial - sub;
        root_d = {root_q[30:0], 1'b1};
      end else begin
        rem_d  = trial;
        root_d = {root_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

>>> rtl/core/ratio_merge_geometric_score.sv
// Top level of the ratio merge geometric score block: sequencer, score
// memories and the shared multiplier. Uses rmgs_pkg, rmgs_divider and rmgs_isqrt.
//
// Requests enter on in_valid_i/in_ready_o with op_i, value_i and item_weight_i.
// Every request gives one result on out_valid_o/out_ready_i with score_o,
// mean_o, weight_o and status_o. The single configuration register is
// written through cfg_valid_i/cfg_ready_o/cfg_data_i and is taken at once.
// Start and append go straight to the result; merge runs in the divider.
// Scale multiplies the mean and then each stored score in turn through the
// shared multiplier and one memory port. Score and reduce copy the list
// entry by entry, then per join scan the pairs, take the product and the
// square root and shift the tail entry by entry.
// The block takes one request at a time; in_ready_o is low until the
// result has been taken. When the receiver stalls, the result holds.
// Reset clears the mean, the weight, the score count and the register.
module ratio_merge_geometric_score
  import rmgs_pkg::*;
#(
  parameter int unsigned MAX_SCORES = 64,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [WORD_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [OP_W-1:0]   op_i,
  input  logic [WORD_W-1:0] value_i,
  input  logic [WORD_W-1:0] item_weight_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [WORD_W-1:0] score_o,
  output logic [WORD_W-1:0] mean_o,
  output logic [WORD_W-1:0] weight_o,
  output logic              status_o
);

  localparam int unsigned AW = (MAX_SCORES > 1) ? $clog2(MAX_SCORES) : 1;
  localparam int unsigned CW = $clog2(MAX_SCORES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SCORES);

  logic [WORD_W-1:0] list_mem [MAX_SCORES];
  logic [WORD_W-1:0] work_mem [MAX_SCORES];

  state_e state_q, state_d;
  logic [WORD_W-1:0] cfg_q;
  logic [WORD_W-1:0] mean_q, mean_d, weight_q, weight_d;
  logic [CW-1:0] cnt_q, cnt_d, n_q, n_d;
  logic [CW-1:0] idx_q, idx_d, best_q, best_d;
  logic [OP_W-1:0] op_q, op_d;
  logic [WORD_W-1:0] val_q, val_d, w_q, w_d;
  logic [WORD_W-1:0] score_q, score_d;
  logic status_q, status_d;
  logic up_q, up_d;
  logic [WORD_W-1:0] a_q, a_d, bl_q, bl_d, bs_q, bs_d;
  logic [1:0] bcls_q, bcls_d;
  logic [63:0] prod_q, prod_d;

  logic          l_we, w_we;
  logic [AW-1:0] l_wa, l_ra, w_wa, w_ra;
  logic [WORD_W-1:0] l_wd, w_wd, l_rd_q, w_rd_q;

  logic [WORD_W-1:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [63:0] sc_shift;
  logic [WORD_W-1:0] sc_sat;

  logic div_start, div_busy, sq_start, sq_busy;
  logic [63:0] div_dividend, div_quot;
  logic [32:0] div_divisor;
  logic [31:0] sq_root;

  logic [WORD_W-1:0] lg, sm;
  logic [1:0] cls;
  logic take;
  logic [32:0] total;
  logic [WORD_W-1:0] diff;

  assign mul_p    = {32'd0, mul_a} * {32'd0, mul_b};
  assign sc_shift = prod_q >> FRAC_BITS;
  assign sc_sat   = (sc_shift[63:32] != '0) ? '1 : sc_shift[31:0];

  rmgs_divider u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .busy_o    (div_busy),
    .quot_o    (div_quot)
  );

  rmgs_isqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sq_start),
    .rad_i  (prod_q),
    .busy_o (sq_busy),
    .root_o (sq_root)
  );

  always_ff @(posedge clk_i) begin
    if (l_we) begin
      list_mem[l_wa] <= l_wd;
    end
    l_rd_q <= list_mem[l_ra];
  end

  always_ff @(posedge clk_i) begin
    if (w_we) begin
      work_mem[w_wa] <= w_wd;
    end
    w_rd_q <= work_mem[w_ra];
  end

  always_comb begin
    state_d  = state_q;
    mean_d   = mean_q;
    weight_d = weight_q;
    cnt_d    = cnt_q;
    n_d      = n_q;
    idx_d    = idx_q;
    best_d   = best_q;
    op_d     = op_q;
    val_d    = val_q;
    w_d      = w_q;
    score_d  = score_q;
    status_d = status_q;
    up_d     = up_q;
    a_d      = a_q;
    bl_d     = bl_q;
    bs_d     = bs_q;
    bcls_d   = bcls_q;
    prod_d   = prod_q;
    l_we = 1'b0;
    l_wa = '0;
    l_wd = '0;
    l_ra = idx_q[AW-1:0];
    w_we = 1'b0;
    w_wa = '0;
    w_wd = '0;
    w_ra = idx_q[AW-1:0];
    mul_a = '0;
    mul_b = '0;
    div_start = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    sq_start = 1'b0;
    total = {1'b0, weight_q} + {1'b0, w_q};
    diff  = up_q ? (val_q - mean_q) : (mean_q - val_q);
    lg  = (a_q > w_rd_q) ? a_q : w_rd_q;
    sm  = (a_q > w_rd_q) ? w_rd_q : a_q;
    cls = (sm != '0) ? 2'd0 : ((lg != '0) ? 2'd1 : 2'd2);
    take = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d = op_i;
          val_d = value_i;
          w_d = item_weight_i;
          score_d = '0;
          status_d = 1'b0;
          idx_d = '0;
          case (op_i)
            OP_START: begin
              mean_d = value_i;
              weight_d = item_weight_i;
              l_we = 1'b1;
              l_wd = value_i;
              cnt_d = CW'(1);
              state_d = ST_OUT;
            end
            OP_MERGE: begin
              up_d = value_i >= mean_q;
              state_d = ST_DIV;
              prod_d = '0;
            end
            OP_APPEND: begin
              if (cnt_q < MAX_CNT) begin
                l_we = 1'b1;
                l_wa = cnt_q[AW-1:0];
                l_wd = value_i;
                cnt_d = cnt_q + CW'(1);
              end else begin
                status_d = 1'b1;
              end
              state_d = ST_OUT;
            end
            OP_SCALE: state_d = ST_SCALE_MEAN;
            OP_SCORE, OP_REDUCE: begin
              if (cnt_q == '0) begin
                score_d = cfg_q;
                state_d = ST_FIN;
              end else begin
                n_d = cnt_q;
                state_d = ST_CPY_RD;
              end
            end
            default: state_d = ST_OUT;
          endcase
        end
      end
      ST_DIV: begin
        if (prod_q == '0 && !div_busy) begin
          mul_a = w_q;
          mul_b = diff;
          prod_d = mul_p | 64'd0;
          if (total == '0) begin
            weight_d = '0;
            state_d = ST_OUT;
          end else begin
            div_start = 1'b1;
            div_dividend = mul_p;
            div_divisor = total;
            prod_d = 64'd1;
          end
        end else if (!div_busy) begin
          mean_d = up_q ? (mean_q + div_quot[31:0]) : (mean_q - div_quot[31:0]);
          weight_d = total[32] ? '1 : total[31:0];
          state_d = ST_OUT;
        end
      end
      ST_SCALE_MEAN: begin
        mul_a = mean_q;
        mul_b = val_q;
        prod_d = mul_p;
        state_d = ST_SCALE_RD;
      end
      ST_SCALE_RD: begin
        if (idx_q == '0) begin
          mean_d = sc_sat;
        end
        if (idx_q >= cnt_q) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_SCALE_WAIT;
        end
      end
      ST_SCALE_WAIT: state_d = ST_SCALE_MUL;
      ST_SCALE_MUL: begin
        mul_a = l_rd_q;
        mul_b = val_q;
        prod_d = mul_p;
        state_d = ST_SHIFT_WR;
      end
      ST_SHIFT_WR: begin
        if (op_q == OP_SCALE) begin
          l_we = 1'b1;
          l_wa = idx_q[AW-1:0];
          l_wd = sc_sat;
          idx_d = idx_q + CW'(1);
          if (idx_q + CW'(1) >= cnt_q) begin
            state_d = ST_OUT;
          end else begin
            state_d = ST_SCALE_WAIT;
            l_ra = idx_q[AW-1:0] + AW'(1);
          end
        end else begin
          w_we = 1'b1;
          w_wa = idx_q[AW-1:0];
          w_wd = w_rd_q;
          idx_d = idx_q + CW'(1);
          if (idx_q + CW'(2) >= n_q) begin
            n_d = n_q - CW'(1);
            idx_d = '0;
            state_d = (n_q - CW'(1) > CW'(1)) ? ST_SCAN_RD : ST_FIN_RD;
          end else begin
            state_d = ST_SHIFT_RD;
          end
        end
      end
      ST_CPY_RD: state_d = ST_CPY_WR;
      ST_CPY_WR: begin
        w_we = 1'b1;
        w_wa = idx_q[AW-1:0];
        w_wd = l_rd_q;
        idx_d = idx_q + CW'(1);
        if (idx_q + CW'(1) >= n_q) begin
          idx_d = '0;
          state_d = (n_q > CW'(1)) ? ST_SCAN_RD : ST_FIN_RD;
        end else begin
          state_d = ST_CPY_RD;
          l_ra = idx_q[AW-1:0] + AW'(1);
        end
      end
      ST_SCAN_RD: begin
        w_ra = idx_q[AW-1:0];
        state_d = ST_SCAN_CMP;
        if (idx_q != '0) begin
          a_d = w_rd_q;
        end
      end
      ST_SCAN_CMP: begin
        // First cycle of a pass loads the left operand and marks the best pair unset.
        if (idx_q == '0) begin
          a_d = w_rd_q;
          idx_d = CW'(1);
          w_ra = AW'(1);
          state_d = ST_SCAN_CMP;
          bcls_d = 2'd3;
        end else begin
          mul_a = lg;
          mul_b = bs_q;
          prod_d = mul_p;
          if (bcls_q == 2'd3) take = 1'b1;
          else if (bcls_q == 2'd2 || cls == 2'd2) take = 1'b0;
          else if (cls == 2'd0 && bcls_q == 2'd1) take = 1'b1;
          else if (cls == 2'd0 && bcls_q == 2'd0) take = mul_p < ({32'd0, bl_q} * {32'd0, sm});
          else take = 1'b0;
          if (take) begin
            best_d = idx_q - CW'(1);
            bl_d = lg;
            bs_d = sm;
            bcls_d = cls;
          end
          a_d = w_rd_q;
          idx_d = idx_q + CW'(1);
          w_ra = idx_q[AW-1:0] + AW'(1);
          if (idx_q + CW'(1) >= n_q) begin
            state_d = ST_SQRT;
            idx_d = '0;
          end
        end
      end
      ST_SQRT: begin
        if (idx_q == '0) begin
          mul_a = bl_q;
          mul_b = bs_q;
          prod_d = mul_p;
          idx_d = CW'(1);
        end else if (idx_q == CW'(1)) begin
          sq_start = 1'b1;
          idx_d = CW'(2);
        end else if (!sq_busy) begin
          w_we = 1'b1;
          w_wa = best_q[AW-1:0];
          w_wd = sq_root;
          idx_d = best_q + CW'(1);
          if (best_q + CW'(2) >= n_q) begin
            n_d = n_q - CW'(1);
            idx_d = '0;
            state_d = (n_q - CW'(1) > CW'(1)) ? ST_SCAN_RD : ST_FIN_RD;
          end else begin
            state_d = ST_SHIFT_RD;
          end
        end
      end
      ST_SHIFT_RD: begin
        w_ra = idx_q[AW-1:0] + AW'(1);
        state_d = ST_SHIFT_WR;
      end
      ST_FIN_RD: begin
        w_ra = '0;
        idx_d = CW'(1);
        if (idx_q == CW'(1)) begin
          score_d = w_rd_q;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (op_q == OP_REDUCE) begin
          l_we = 1'b1;
          l_wa = '0;
          l_wd = score_q;
          cnt_d = CW'(1);
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cfg_q    <= '0;
      mean_q   <= '0;
      weight_q <= '0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      mean_q   <= mean_d;
      weight_q <= weight_d;
      cnt_q    <= cnt_d;
      if (cfg_valid_i) begin
        cfg_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    idx_q    <= idx_d;
    best_q   <= best_d;
    op_q     <= op_d;
    val_q    <= val_d;
    w_q      <= w_d;
    score_q  <= score_d;
    status_q <= status_d;
    up_q     <= up_d;
    a_q      <= a_d;
    bl_q     <= bl_d;
    bs_q     <= bs_d;
    bcls_q   <= bcls_d;
    prod_q   <= prod_d;
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign score_o     = score_q;
  assign mean_o      = mean_q;
  assign weight_o    = weight_q;
  assign status_o    = status_q;

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MAX_CNT) else $error("score count beyond capacity");
  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");
  a_status_only_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> op_q == OP_APPEND) else $error("bad status");
  a_score_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && op_q != OP_SCORE && op_q != OP_REDUCE |-> score_o == '0)
    else $error("score on wrong op");
`endif

endmodule

>>> sim/tb.sv
// Testbench for ratio_merge_geometric_score: drives random and directed requests
// and checks every result against a scoreboard that predicts the block.
// Depends on rmgs_pkg and the block's RTL only.
module tb;
  import rmgs_pkg::*;

  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int unsigned LIST_MAX = 64;
  localparam int unsigned CYCLE_LIMIT = 10000000;

  typedef struct packed {
    logic [31:0] score;
    logic [31:0] mean;
    logic [31:0] weight;
    logic        status;
  } result_t;

  class score_board;
    logic [31:0] empty_score;
    logic [31:0] mean;
    logic [31:0] total;
    logic [31:0] list [LIST_MAX];
    int unsigned count;
    result_t     expected_q[$];
    int          errors;

    function new();
      empty_score = '0;
      mean = '0;
      total = '0;
      count = 0;
      errors = 0;
    endfunction

    function logic [31:0] scale_word(logic [31:0] x, logic [31:0] f);
      logic [63:0] p;
      p = ({32'b0, x} * {32'b0, f}) >> 16;
      return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
    endfunction

    function logic [31:0] floor_sqrt(logic [63:0] x);
      logic [31:0] r;
      logic [31:0] t;
      r = '0;
      for (int b = 31; b >= 0; b--) begin
        t = r | (32'd1 << b);
        if ({32'b0, t} * {32'b0, t} <= x) r = t;
      end
      return r;
    endfunction

    function logic [31:0] join_scores();
      logic [31:0] work [LIST_MAX];
      int unsigned n;
      int unsigned best;
      logic [63:0] bl, bs, lg, sm;
      int bcls, cls;
      bit take;
      if (count == 0) return empty_score;
      n = count;
      for (int i = 0; i < n; i++) work[i] = list[i];
      while (n > 1) begin
        best = 0; bl = 0; bs = 0; bcls = 0;
        for (int i = 0; i + 1 < n; i++) begin
          lg = (work[i] > work[i+1]) ? work[i] : work[i+1];
          sm = (work[i] > work[i+1]) ? work[i+1] : work[i];
          cls = (sm != 0) ? 0 : ((lg != 0) ? 1 : 2);
          if (i == 0) take = 1;
          else if (bcls == 2 || cls == 2) take = 0;
          else if (cls == 0 && bcls == 1) take = 1;
          else if (cls == 0 && bcls == 0) take = (lg * bs) < (bl * sm);
          else take = 0;
          if (take) begin
            best = i; bl = lg; bs = sm; bcls = cls;
          end
        end
        work[best] = floor_sqrt({32'b0, work[best]} * {32'b0, work[best+1]});
        for (int i = best + 1; i + 1 < n; i++) work[i] = work[i+1];
        n--;
      end
      return work[0];
    endfunction

    function void note_request(logic [2:0] op, logic [31:0] v, logic [31:0] w);
      result_t r;
      logic [32:0] sum;
      logic [63:0] step;
      r = '0;
      case (op)
        OP_START: begin
          mean = v; total = w; list[0] = v; count = 1;
        end
        OP_MERGE: begin
          sum = {1'b0, total} + {1'b0, w};
          if (sum != 0) begin
            if (v >= mean) begin
              step = ({32'b0, w} * {32'b0, v - mean}) / {31'b0, sum};
              mean = mean + step[31:0];
            end else begin
              step = ({32'b0, w} * {32'b0, mean - v}) / {31'b0, sum};
              mean = mean - step[31:0];
            end
          end
          total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end
        OP_APPEND: begin
          if (count < LIST_MAX) begin
            list[count] = v; count++;
          end else r.status = 1'b1;
        end
        OP_SCALE: begin
          mean = scale_word(mean, v);
          for (int i = 0; i < count; i++) list[i] = scale_word(list[i], v);
        end
        OP_SCORE: r.score = join_scores();
        OP_REDUCE: begin
          r.score = join_scores();
          list[0] = r.score; count = 1;
        end
        default: ;
      endcase
      r.mean = mean;
      r.weight = total;
      expected_q = {expected_q, r};
    endfunction

    function void check_result(result_t got);
      result_t e;
      if (expected_q.size() == 0) begin
        $error("result with no request waiting");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.score !== e.score) begin
        $error("score expected %h actual %h", e.score, got.score); errors++;
      end
      if (got.mean !== e.mean) begin
        $error("mean expected %h actual %h", e.mean, got.mean); errors++;
      end
      if (got.weight !== e.weight) begin
        $error("weight expected %h actual %h", e.weight, got.weight); errors++;
      end
      if (got.status !== e.status) begin
        $error("status expected %b actual %b", e.status, got.status); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  op_i = '0;
  logic [31:0] value_i = '0;
  logic [31:0] item_weight_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] score_o, mean_o, weight_o;
  logic        status_o;

  score_board  sb = new();
  bit          quiet = 1'b0;
  int unsigned cycles = 0;
  int unsigned sent = 0;

  ratio_merge_geometric_score dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_ready_o, .op_i, .value_i, .item_weight_i,
    .out_valid_o, .out_ready_i, .score_o, .mean_o,
    .weight_o, .status_o
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_result('{score: score_o, mean: mean_o, weight: weight_o,
                          status: status_o});
      out_ready_i <= quiet ? 1'b1 : ($urandom_range(99) >= 15);
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(3);
      3: return 32'h0001_0000 + $urandom_range(32'h0000_FFFF) - 32'h8000;
      4: return $urandom_range(32'h000F_FFFF);
      default: return $urandom;
    endcase
  endfunction

  task automatic send(logic [2:0] op, logic [31:0] v, logic [31:0] w);
    if (!quiet && $urandom_range(99) < 15) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    value_i <= v;
    item_weight_i <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(op, v, w);
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [31:0] d);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.empty_score = d;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_sequence();
    int unsigned n;
    send(OP_START, pick_word(), pick_word());
    n = ($urandom_range(19) == 0) ? 66 : $urandom_range(6);
    for (int i = 0; i < n; i++) send(OP_APPEND, pick_word(), $urandom);
    repeat ($urandom_range(3)) send(OP_MERGE, pick_word(), pick_word());
    if ($urandom_range(2) == 0) send(OP_SCALE, pick_word(), $urandom);
    send($urandom_range(1) ? OP_SCORE : OP_REDUCE, $urandom, $urandom);
    if ($urandom_range(1)) send(OP_SCORE, $urandom, $urandom);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_cfg(32'hFFFF_FFFF);
    send(OP_SCORE, $urandom, $urandom);
    send(OP_REDUCE, $urandom, $urandom);
    send(OP_SPARE_LO, $urandom, $urandom);
    send(OP_SPARE_HI, $urandom, $urandom);
    write_cfg(32'h0);
    send(OP_START, 32'h0003_0000, 32'h0);
    send(OP_MERGE, 32'hFFFF_FFFF, 32'h0);
    send(OP_MERGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(OP_MERGE, 32'h0, 32'hFFFF_FFFF);
    send(OP_APPEND, 32'h0, 32'h0);
    send(OP_APPEND, 32'h0, 32'h0);
    send(OP_APPEND, 32'hFFFF_FFFF, 32'h0);
    send(OP_APPEND, 32'h0000_0001, 32'h0);
    send(OP_APPEND, 32'h0, 32'h0);
    send(OP_SCORE, 32'h0, 32'h0);
    send(OP_SCALE, 32'hFFFF_FFFF, 32'h0);
    send(OP_SCORE, 32'h0, 32'h0);
    send(OP_SCALE, 32'h0000_8000, 32'h0);
    send(OP_REDUCE, 32'h0, 32'h0);
    send(OP_START, 32'h0, 32'hFFFF_FFFF);
    send(OP_APPEND, 32'h0, 32'h0);
    send(OP_APPEND, 32'h0, 32'h0);
    send(OP_SCORE, 32'h0, 32'h0);
    write_cfg($urandom);
    while (sent < 130) begin
      quiet = (sent >= 70 && sent < 105);
      if ($urandom_range(4) == 0) send(3'($urandom_range(7)), pick_word(), pick_word());
      else run_sequence();
      if ($urandom_range(9) == 0) drain();
    end
    quiet = 1'b0;
    write_cfg($urandom);
    drain();
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
